// ===== rtl/core/quadratic_nearest_root_assert.svh =====
// Assertion macros shared by the quadratic root block.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef QUADRATIC_NEAREST_ROOT_ASSERT_SVH
`define QUADRATIC_NEAREST_ROOT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define QNR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define QNR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/qnr_pkg.sv =====
package qnr_pkg;

  // Field and internal widths.
  localparam int COEF_W = 32;
  localparam int ROOT_W = 31;
  localparam int DISC_W = 66;
  localparam int SQRT_W = 34;
  localparam int REM_W  = 36;
  localparam int NUM_W  = 36;
  localparam int MAG_W  = 34;
  localparam int DEN_W  = 33;

  localparam logic [ROOT_W-1:0] ROOT_MAX = '1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NEG_DISC = 2'd1,
    ST_NO_ROOT  = 2'd2,
    ST_A_ZERO   = 2'd3
  } status_t;

  // Information that travels alongside the arithmetic through the pipeline.
  typedef struct packed {
    logic              valid;
    status_t           status;
    logic              a_neg;
    logic [COEF_W-1:0] coef_b;
    logic [COEF_W-1:0] mag_a;
  } qnr_side_t;

endpackage

// ===== rtl/core/qnr_disc.sv =====
module qnr_disc
  import qnr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [COEF_W-1:0] coef_a,
  input  logic [COEF_W-1:0] coef_b,
  input  logic [COEF_W-1:0] coef_c,
  output qnr_side_t         side_o,
  output logic [DISC_W-1:0] disc_o
);

  qnr_side_t         s1_side_r, s2_side_r, s3_side_r;
  logic [COEF_W-1:0] s1_mag_b_r, s1_mag_c_r;
  logic              s1_a_zero_r, s1_ac_pos_r, s2_a_zero_r, s2_ac_pos_r;
  logic [63:0]       s2_b2_r, s2_p_r;
  logic [DISC_W-1:0] s3_disc_r;

  logic [COEF_W-1:0] mag_a, mag_b, mag_c;
  logic [63:0]       b2_nxt, p_nxt;
  logic [DISC_W-1:0] b2_w, p4_w, disc_nxt;
  logic              neg_nxt;
  status_t           status_nxt;

  // Magnitudes of the coefficients; the most negative value fits unsigned.
  assign mag_a = coef_a[COEF_W-1] ? (~coef_a + 1'b1) : coef_a;
  assign mag_b = coef_b[COEF_W-1] ? (~coef_b + 1'b1) : coef_b;
  assign mag_c = coef_c[COEF_W-1] ? (~coef_c + 1'b1) : coef_c;

  // Stage one: signs and magnitudes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_side_r <= '0;
    end else if (en) begin
      s1_side_r.valid  <= in_valid;
      s1_side_r.status <= ST_OK;
      s1_side_r.a_neg  <= coef_a[COEF_W-1];
      s1_side_r.coef_b <= coef_b;
      s1_side_r.mag_a  <= mag_a;
      s1_mag_b_r       <= mag_b;
      s1_mag_c_r       <= mag_c;
      s1_a_zero_r      <= (coef_a == '0);
      s1_ac_pos_r      <= (coef_c != '0) && (coef_a[COEF_W-1] == coef_c[COEF_W-1]);
    end
  end

  // Stage two: the two products b*b and |a|*|c|.
  assign b2_nxt = s1_mag_b_r * s1_mag_b_r;
  assign p_nxt  = s1_side_r.mag_a * s1_mag_c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_side_r <= '0;
    end else if (en) begin
      s2_side_r   <= s1_side_r;
      s2_b2_r     <= b2_nxt;
      s2_p_r      <= p_nxt;
      s2_a_zero_r <= s1_a_zero_r;
      s2_ac_pos_r <= s1_ac_pos_r;
    end
  end

  // Stage three: exact discriminant and its sign.
  assign b2_w     = {2'b00, s2_b2_r};
  assign p4_w     = {s2_p_r, 2'b00};
  assign neg_nxt  = s2_ac_pos_r && (p4_w > b2_w);
  assign disc_nxt = s2_ac_pos_r ? (b2_w - p4_w) : (b2_w + p4_w);

  always_comb begin
    priority if (s2_a_zero_r) begin
      status_nxt = ST_A_ZERO;
    end else if (neg_nxt) begin
      status_nxt = ST_NEG_DISC;
    end else begin
      status_nxt = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_side_r <= '0;
    end else if (en) begin
      s3_side_r        <= s2_side_r;
      s3_side_r.status <= status_nxt;
      s3_disc_r        <= disc_nxt;
    end
  end

  assign side_o = s3_side_r;
  assign disc_o = s3_disc_r;

endmodule

// ===== rtl/core/qnr_sqrt.sv =====
module qnr_sqrt
  import qnr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  qnr_side_t         side_i,
  input  logic [DISC_W-1:0] disc_i,
  output qnr_side_t         side_o,
  output logic [SQRT_W-1:0] root_o
);

  // The radicand is widened to two bits per result bit, zeros on top.
  localparam int RAD_W = 2 * SQRT_W;

  qnr_side_t         side_r [SQRT_W];
  logic [REM_W-1:0]  rem_r  [SQRT_W];
  logic [SQRT_W-1:0] root_r [SQRT_W];
  logic [RAD_W-1:0]  d_r    [SQRT_W];

  // One result bit per stage, two bits of the radicand shifted in each time.
  for (genvar k = 0; k < SQRT_W; k++) begin : g_stage
    logic [REM_W-1:0]  rem_prev;
    logic [SQRT_W-1:0] root_prev;
    logic [RAD_W-1:0]  d_prev;
    qnr_side_t         side_prev;
    logic [REM_W+1:0]  cur, trial;
    logic              ge;

    if (k == 0) begin : g_first
      assign rem_prev  = '0;
      assign root_prev = '0;
      assign d_prev    = {{(RAD_W-DISC_W){1'b0}}, disc_i};
      assign side_prev = side_i;
    end else begin : g_next
      assign rem_prev  = rem_r[k-1];
      assign root_prev = root_r[k-1];
      assign d_prev    = d_r[k-1];
      assign side_prev = side_r[k-1];
    end

    assign cur   = {rem_prev, d_prev[RAD_W-1 -: 2]};
    assign trial = {2'b00, root_prev, 2'b01};
    assign ge    = (cur >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        side_r[k] <= '0;
      end else if (en) begin
        side_r[k] <= side_prev;
        rem_r[k]  <= ge ? REM_W'(cur - trial) : REM_W'(cur);
        root_r[k] <= {root_prev[SQRT_W-2:0], ge};
        d_r[k]    <= {d_prev[RAD_W-3:0], 2'b00};
      end
    end
  end

  assign side_o = side_r[SQRT_W-1];
  assign root_o = root_r[SQRT_W-1];

endmodule

// ===== rtl/core/qnr_div.sv =====
module qnr_div
  import qnr_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  qnr_side_t         side_i,
  input  logic [SQRT_W-1:0] sqrt_i,
  output qnr_side_t         side_o,
  output logic [ROOT_W-1:0] root_o
);

  localparam int XW = MAG_W + FRAC_BITS;
  localparam int W  = (XW > DEN_W + ROOT_W) ? XW : DEN_W + ROOT_W;

  qnr_side_t         a_side_r, b_side_r, c_side_r;
  logic [NUM_W-1:0]  a_n1_r, a_n2_r;
  logic [MAG_W-1:0]  b_best_r;
  logic [W-1:0]      c_rem_r;
  logic [DEN_W-1:0]  c_den_r;
  logic              c_sat_r;

  qnr_side_t         side_r [ROOT_W];
  logic [W-1:0]      rem_r  [ROOT_W];
  logic [DEN_W-1:0]  den_r  [ROOT_W];
  logic              sat_r  [ROOT_W];
  logic [ROOT_W-1:0] q_r    [ROOT_W];

  logic [NUM_W-1:0] b_ext, neg_b, s_ext;
  logic [NUM_W-1:0] mag1, mag2;
  logic             ok1, ok2;
  logic [MAG_W-1:0] best_nxt;
  status_t          status_b;
  logic [W-1:0]     x_w, den_top;
  logic [DEN_W-1:0] den_nxt;

  // Stage A: both root numerators, -b - s and -b + s.
  assign b_ext = {{(NUM_W-COEF_W){side_i.coef_b[COEF_W-1]}}, side_i.coef_b};
  assign neg_b = '0 - b_ext;
  assign s_ext = {{(NUM_W-SQRT_W){1'b0}}, sqrt_i};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_side_r <= '0;
    end else if (en) begin
      a_side_r <= side_i;
      a_n1_r   <= neg_b - s_ext;
      a_n2_r   <= neg_b + s_ext;
    end
  end

  // Stage B: a root is nonnegative when its numerator is zero or shares the sign of a.
  assign ok1  = (a_n1_r == '0) || (a_n1_r[NUM_W-1] == a_side_r.a_neg);
  assign ok2  = (a_n2_r == '0) || (a_n2_r[NUM_W-1] == a_side_r.a_neg);
  assign mag1 = a_n1_r[NUM_W-1] ? ('0 - a_n1_r) : a_n1_r;
  assign mag2 = a_n2_r[NUM_W-1] ? ('0 - a_n2_r) : a_n2_r;

  always_comb begin
    priority if (ok1 && ok2) begin
      best_nxt = (mag1 < mag2) ? mag1[MAG_W-1:0] : mag2[MAG_W-1:0];
    end else if (ok1) begin
      best_nxt = mag1[MAG_W-1:0];
    end else begin
      best_nxt = mag2[MAG_W-1:0];
    end
    if ((a_side_r.status == ST_OK) && !ok1 && !ok2) begin
      status_b = ST_NO_ROOT;
    end else begin
      status_b = a_side_r.status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_side_r <= '0;
    end else if (en) begin
      b_side_r        <= a_side_r;
      b_side_r.status <= status_b;
      b_best_r        <= best_nxt;
    end
  end

  // Stage C: scaled dividend, and the check for a quotient beyond the field.
  assign den_nxt = {b_side_r.mag_a, 1'b0};
  assign x_w     = {{(W-MAG_W){1'b0}}, b_best_r} << FRAC_BITS;
  assign den_top = {{(W-DEN_W){1'b0}}, den_nxt} << ROOT_W;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_side_r <= '0;
    end else if (en) begin
      c_side_r <= b_side_r;
      c_rem_r  <= x_w;
      c_den_r  <= den_nxt;
      c_sat_r  <= (x_w >= den_top);
    end
  end

  // Restoring division, one quotient bit per stage from the top bit down.
  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    localparam int SH = ROOT_W - 1 - k;
    qnr_side_t         side_prev;
    logic [W-1:0]      rem_prev, trial;
    logic [DEN_W-1:0]  den_prev;
    logic              sat_prev, ge;
    logic [ROOT_W-1:0] q_prev;

    if (k == 0) begin : g_first
      assign side_prev = c_side_r;
      assign rem_prev  = c_rem_r;
      assign den_prev  = c_den_r;
      assign sat_prev  = c_sat_r;
      assign q_prev    = '0;
    end else begin : g_next
      assign side_prev = side_r[k-1];
      assign rem_prev  = rem_r[k-1];
      assign den_prev  = den_r[k-1];
      assign sat_prev  = sat_r[k-1];
      assign q_prev    = q_r[k-1];
    end

    assign trial = {{(W-DEN_W){1'b0}}, den_prev} << SH;
    assign ge    = (rem_prev >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        side_r[k] <= '0;
      end else if (en) begin
        side_r[k] <= side_prev;
        rem_r[k]  <= ge ? (rem_prev - trial) : rem_prev;
        den_r[k]  <= den_prev;
        sat_r[k]  <= sat_prev;
        q_r[k]    <= {q_prev[ROOT_W-2:0], ge};
      end
    end
  end

  // Root is zero unless one was found; a quotient beyond the field saturates.
  assign side_o = side_r[ROOT_W-1];
  assign root_o = (side_r[ROOT_W-1].status != ST_OK) ? '0 :
                  sat_r[ROOT_W-1] ? ROOT_MAX : q_r[ROOT_W-1];

endmodule

// ===== rtl/core/quadratic_nearest_root.sv =====
// Smallest nonnegative root of a*t^2 + b*t + c = 0 for signed fixed-point
// coefficients with FRAC_BITS fraction bits.
// Input channel in_*: tdata carries coef_a, coef_b and coef_c, 32 bits each.
// Output channel out_*: tdata carries the root (unsigned, saturated), tuser
// the status: 0 root found, 1 negative discriminant, 2 no nonnegative root,
// 3 coefficient a is zero. The root reads zero unless the status is 0.
// Throughput is one request per cycle while in_tready is high. A request
// passes 72 register stages, the first loaded at the accept edge and the
// last driving out_tvalid: three for the products and discriminant, 34 for the square
// root (one result bit per stage), 34 for root selection and the division
// (one quotient bit per stage), and one for the output register.
// Reset clears every valid bit of the pipeline, the output register and the
// skid slot; no request is then in flight.
// When the receiver stalls, the pipeline keeps moving until one result is
// held at the output and one more in the skid slot; then in_tready falls
// and the whole pipeline holds until the output is taken. Nothing is lost.
`include "quadratic_nearest_root_assert.svh"

module quadratic_nearest_root
  import qnr_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // coef_a [31:0], coef_b [63:32], coef_c [95:64]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // root [30:0], zero [31]
  output logic [1:0]  out_tuser   // status [1:0]
);

  logic              en;
  qnr_side_t         disc_side, sqrt_side, pipe_side;
  logic [DISC_W-1:0] disc;
  logic [SQRT_W-1:0] sqrt_root;
  logic [ROOT_W-1:0] pipe_root;

  logic              out_valid_r, skid_valid_r;
  logic [ROOT_W-1:0] out_root_r, skid_root_r;
  status_t           out_status_r, skid_status_r;
  logic              out_free;

  // The pipeline holds only while the skid slot is occupied.
  assign en        = !skid_valid_r;
  assign in_tready = en;

  qnr_disc u_disc (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_tvalid),
    .coef_a   (in_tdata[31:0]),
    .coef_b   (in_tdata[63:32]),
    .coef_c   (in_tdata[95:64]),
    .side_o   (disc_side),
    .disc_o   (disc)
  );

  qnr_sqrt u_sqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .side_i (disc_side),
    .disc_i (disc),
    .side_o (sqrt_side),
    .root_o (sqrt_root)
  );

  qnr_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .side_i (sqrt_side),
    .sqrt_i (sqrt_root),
    .side_o (pipe_side),
    .root_o (pipe_root)
  );

  // Output register with a one-entry skid slot behind it.
  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_tready) begin
        out_valid_r   <= 1'b1;
        out_root_r    <= skid_root_r;
        out_status_r  <= skid_status_r;
        skid_valid_r  <= 1'b0;
      end
    end else if (out_free) begin
      out_valid_r  <= pipe_side.valid;
      out_root_r   <= pipe_root;
      out_status_r <= pipe_side.status;
    end else if (pipe_side.valid) begin
      skid_valid_r  <= 1'b1;
      skid_root_r   <= pipe_root;
      skid_status_r <= pipe_side.status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_root_r};
  assign out_tuser  = out_status_r;

  `QNR_ASSERT_NOW(a_skid_behind_out, skid_valid_r, out_valid_r, "skid without output")
  `QNR_ASSERT_NEXT(a_skid_kept, skid_valid_r && !out_tready, skid_valid_r, "skid entry dropped")
  `QNR_ASSERT_NOW(a_root_zero, out_valid_r && (out_status_r != ST_OK), out_root_r == '0, "root set")

endmodule
